FILE: src/dlp_pkg.sv
`default_nettype none
package dlp_pkg;

	localparam int NUM_RESONANCES = 5;
	localparam int NUM_TERMS      = NUM_RESONANCES + 1;

	localparam int DIV_BITS = 40;
	localparam int DEN_W    = 65;
	localparam int NUM_W    = 92;
	localparam int TERM_W   = 42;
	localparam int SUM_W    = 44;

	// term front end stages, divider cells, term output register
	localparam int TERM_LAT = 5 + DIV_BITS + 1;
	// input register, term, sum register
	localparam int PIPE_LEN = TERM_LAT + 2;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	localparam logic [CFG_IDX_W-1:0] REG_PLASMA = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DRUDE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LAST   = 3'd6;

	localparam logic [15:0]        PLASMA_RST = 16'd2312;
	localparam logic [SUM_W-1:0]   ONE_Q16    = SUM_W'(65536);
	localparam logic [DIV_BITS-1:0] TERM_MAX  = {DIV_BITS{1'b1}};

	typedef struct packed {
		logic [15:0] strength;
		logic [15:0] damping;
		logic [15:0] resonance;
	} term_cfg_t;

	typedef struct packed {
		logic signed [TERM_W-1:0] re;
		logic signed [TERM_W-1:0] im;
		logic                     fault;
	} term_res_t;

	typedef struct packed {
		logic a_neg;
		logic zero;
		logic big_re;
		logic big_im;
	} term_flags_t;

endpackage
`default_nettype wire

FILE: src/drude_lorentz_permittivity.sv
// Drude-Lorentz permittivity: each photon energy (Q4.12 eV) yields eps_real and eps_imag in
// signed Q16.16 plus range_fault. One request is taken every cycle while in_stall is low; each
// term carries five front-end stages and then two rows of 40 restoring-division cells (one
// quotient bit per cell). Write the plasma energy and term registers only while no request is
// in flight.
`default_nettype none
module drude_lorentz_permittivity (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [15:0]                      photon_energy,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic signed [31:0]                    eps_real,
	output logic signed [31:0]                    eps_imag,
	output logic                                  range_fault,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [dlp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [dlp_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int NT = dlp_pkg::NUM_TERMS;
	localparam int PL = dlp_pkg::PIPE_LEN;
	localparam int SW = dlp_pkg::SUM_W;

	logic [15:0]                      plasma_q;
	logic [dlp_pkg::CFG_DATA_W-1:0]   term_q [NT];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plasma_q <= dlp_pkg::PLASMA_RST;
			for (int k = 0; k < NT; k++) begin
				term_q[k] <= '0;
			end
		end else if (cfg_valid) begin
			if (cfg_index == dlp_pkg::REG_PLASMA) begin
				plasma_q <= cfg_data[15:0];
			end
			for (int k = 0; k < NT; k++) begin
				if (cfg_index == dlp_pkg::CFG_IDX_W'(k + 1) && cfg_index <= dlp_pkg::REG_LAST) begin
					term_q[k] <= cfg_data;
				end
			end
		end
	end

	logic adv;
	logic skid_v_q, out_v_q;
	logic [PL-1:0] vld_q;
	logic [15:0]   w_s1;

	assign adv      = !skid_v_q;
	assign in_stall = skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[PL-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			w_s1 <= photon_energy;
		end
	end

	dlp_pkg::term_cfg_t coef [NT];
	dlp_pkg::term_res_t res  [NT];

	for (genvar k = 0; k < NT; k++) begin : g_terms
		// the free-electron term has no resonance
		if (k == 0) begin : g_drude
			assign coef[k] = {term_q[k][47:16], 16'h0000};
		end else begin : g_osc
			assign coef[k] = term_q[k];
		end
		dlp_term u_term (
			.clk    (clk),
			.en     (adv),
			.energy (w_s1),
			.plasma (plasma_q),
			.coef   (coef[k]),
			.res    (res[k])
		);
	end

	logic signed [SW-1:0] sre, sim;
	logic                 sflt;
	logic signed [SW-1:0] re_s2, im_s2;
	logic                 flt_s2;

	always_comb begin
		sre  = dlp_pkg::ONE_Q16;
		sim  = '0;
		sflt = 1'b0;
		for (int k = 0; k < NT; k++) begin
			sre  = sre + SW'(res[k].re);
			sim  = sim + SW'(res[k].im);
			sflt = sflt | res[k].fault;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			re_s2  <= sre;
			im_s2  <= sim;
			flt_s2 <= sflt;
		end
	end

	localparam logic signed [SW-1:0] MAX32 = SW'(64'sh7fffffff);
	localparam logic signed [SW-1:0] MIN32 = -SW'(64'sh80000000);

	logic [31:0] ore, oim;
	logic        ohi_re, olo_re, ohi_im, olo_im, oflt;

	assign ohi_re = re_s2 > MAX32;
	assign olo_re = re_s2 < MIN32;
	assign ohi_im = im_s2 > MAX32;
	assign olo_im = im_s2 < MIN32;
	assign ore  = ohi_re ? 32'h7fffffff : olo_re ? 32'h80000000 : re_s2[31:0];
	assign oim  = ohi_im ? 32'h7fffffff : olo_im ? 32'h80000000 : im_s2[31:0];
	assign oflt = flt_s2 | ohi_re | olo_re | ohi_im | olo_im;

	logic push, take;
	logic [31:0] out_re_q, out_im_q, skid_re_q, skid_im_q;
	logic        out_flt_q, skid_flt_q;

	assign push = adv && vld_q[PL-1];
	assign take = out_v_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (take) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= push;
			end
		end else if (push) begin
			if (out_v_q) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (skid_v_q) begin
				out_re_q  <= skid_re_q;
				out_im_q  <= skid_im_q;
				out_flt_q <= skid_flt_q;
			end else begin
				out_re_q  <= ore;
				out_im_q  <= oim;
				out_flt_q <= oflt;
			end
		end else if (push) begin
			if (out_v_q) begin
				skid_re_q  <= ore;
				skid_im_q  <= oim;
				skid_flt_q <= oflt;
			end else begin
				out_re_q  <= ore;
				out_im_q  <= oim;
				out_flt_q <= oflt;
			end
		end
	end

	assign out_valid   = out_v_q;
	assign eps_real    = out_re_q;
	assign eps_imag    = out_im_q;
	assign range_fault = out_flt_q;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid holds a result while the output register is empty");

	a_tail_held: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[PL-1] && !adv) |=> vld_q[PL-1])
		else $error("result at the pipeline tail lost while held");

	a_skid_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(push && out_v_q && out_stall) |=> skid_v_q)
		else $error("result pushed into a blocked output not kept in skid");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(take && skid_v_q) |=> (out_v_q && !skid_v_q))
		else $error("skid result not moved to the output register");

endmodule
`default_nettype wire

FILE: src/dlp_div_cell.sv
`default_nettype none
module dlp_div_cell (
	input  wire logic                             clk,
	input  wire logic                             en,
	input  wire logic [dlp_pkg::DEN_W-1:0]        rem,
	input  wire logic [dlp_pkg::DIV_BITS-1:0]     nlo,
	input  wire logic [dlp_pkg::DIV_BITS-1:0]     quo,
	input  wire logic [dlp_pkg::DEN_W-1:0]        den,
	output logic      [dlp_pkg::DEN_W-1:0]        next_rem,
	output logic      [dlp_pkg::DIV_BITS-1:0]     next_nlo,
	output logic      [dlp_pkg::DIV_BITS-1:0]     next_quo,
	output logic      [dlp_pkg::DEN_W-1:0]        next_den
);

	logic [dlp_pkg::DEN_W:0]      trial;
	logic                         ge;
	logic [dlp_pkg::DEN_W-1:0]    rem_q;
	logic [dlp_pkg::DIV_BITS-1:0] nlo_q;
	logic [dlp_pkg::DIV_BITS-1:0] quo_q;
	logic [dlp_pkg::DEN_W-1:0]    den_q;

	// bring down the next numerator bit and try one subtraction
	assign trial = {rem, nlo[dlp_pkg::DIV_BITS-1]};
	assign ge    = trial >= {1'b0, den};

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= ge ? dlp_pkg::DEN_W'(trial - {1'b0, den})
				: trial[dlp_pkg::DEN_W-1:0];
			nlo_q <= {nlo[dlp_pkg::DIV_BITS-2:0], 1'b0};
			quo_q <= {quo[dlp_pkg::DIV_BITS-2:0], ge};
			den_q <= den;
		end
	end

	assign next_rem = rem_q;
	assign next_nlo = nlo_q;
	assign next_quo = quo_q;
	assign next_den = den_q;

endmodule
`default_nettype wire

FILE: src/dlp_term.sv
`default_nettype none
module dlp_term (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic [15:0]        energy,
	input  wire logic [15:0]        plasma,
	input  wire dlp_pkg::term_cfg_t coef,
	output dlp_pkg::term_res_t      res
);

	localparam int DB = dlp_pkg::DIV_BITS;
	localparam int DW = dlp_pkg::DEN_W;
	localparam int NW = dlp_pkg::NUM_W;
	localparam int TW = dlp_pkg::TERM_W;

	// stage 1: squares and damping product
	logic [31:0] ww_s1, rr_s1, b_s1, pp_s1;
	// stage 2: signed detuning and numerator
	logic        a_neg_s2;
	logic [31:0] amag_s2, b_s2;
	logic [47:0] num_s2;
	logic [32:0] diff;
	// stage 3: partial products
	logic        a_neg_s3;
	logic [63:0] aa_s3, bb_s3;
	logic [55:0] re_hi_s3, re_lo_s3, im_hi_s3, im_lo_s3;
	// stage 4: assembled numerators and denominator
	logic          a_neg_s4;
	logic [DW-1:0] den_s4;
	logic [NW-1:0] nre_s4, nim_s4;
	logic [79:0]   pre, pim;
	// stage 5: divider set-up
	dlp_pkg::term_flags_t flags_s5;
	logic [DW-1:0] den_s5;
	logic [DW-1:0] rre_s5, rim_s5;
	logic [DB-1:0] lre_s5, lim_s5;
	logic [DW-1:0] hre, him;

	always_ff @(posedge clk) begin
		if (en) begin
			ww_s1 <= 32'(energy) * 32'(energy);
			rr_s1 <= 32'(coef.resonance) * 32'(coef.resonance);
			b_s1  <= 32'(energy) * 32'(coef.damping);
			pp_s1 <= 32'(plasma) * 32'(plasma);
		end
	end

	assign diff = {1'b0, rr_s1} - {1'b0, ww_s1};

	always_ff @(posedge clk) begin
		if (en) begin
			a_neg_s2 <= diff[32];
			amag_s2  <= diff[32] ? 32'(-diff) : diff[31:0];
			b_s2     <= b_s1;
			num_s2   <= 48'(coef.strength) * 48'(pp_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_neg_s3 <= a_neg_s2;
			aa_s3    <= 64'(amag_s2) * 64'(amag_s2);
			bb_s3    <= 64'(b_s2) * 64'(b_s2);
			re_hi_s3 <= 56'(num_s2[47:24]) * 56'(amag_s2);
			re_lo_s3 <= 56'(num_s2[23:0]) * 56'(amag_s2);
			im_hi_s3 <= 56'(num_s2[47:24]) * 56'(b_s2);
			im_lo_s3 <= 56'(num_s2[23:0]) * 56'(b_s2);
		end
	end

	assign pre = (80'(re_hi_s3) << 24) + 80'(re_lo_s3);
	assign pim = (80'(im_hi_s3) << 24) + 80'(im_lo_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			a_neg_s4 <= a_neg_s3;
			den_s4   <= DW'(aa_s3) + DW'(bb_s3);
			nre_s4   <= {pre, 12'h000};
			nim_s4   <= {pim, 12'h000};
		end
	end

	// quotient reaches 2^40 exactly when the upper numerator bits reach the denominator
	assign hre = DW'(nre_s4[NW-1:DB]);
	assign him = DW'(nim_s4[NW-1:DB]);

	always_ff @(posedge clk) begin
		if (en) begin
			flags_s5.a_neg  <= a_neg_s4;
			flags_s5.zero   <= den_s4 == '0;
			flags_s5.big_re <= hre >= den_s4;
			flags_s5.big_im <= him >= den_s4;
			den_s5 <= den_s4;
			rre_s5 <= hre;
			rim_s5 <= him;
			lre_s5 <= nre_s4[DB-1:0];
			lim_s5 <= nim_s4[DB-1:0];
		end
	end

	// two rows of division cells, one quotient bit per cell
	logic [DW-1:0] re_rem [DB+1];
	logic [DB-1:0] re_nlo [DB+1];
	logic [DB-1:0] re_quo [DB+1];
	logic [DW-1:0] re_den [DB+1];
	logic [DW-1:0] im_rem [DB+1];
	logic [DB-1:0] im_nlo [DB+1];
	logic [DB-1:0] im_quo [DB+1];
	logic [DW-1:0] im_den [DB+1];

	assign re_rem[0] = rre_s5;
	assign re_nlo[0] = lre_s5;
	assign re_quo[0] = '0;
	assign re_den[0] = den_s5;
	assign im_rem[0] = rim_s5;
	assign im_nlo[0] = lim_s5;
	assign im_quo[0] = '0;
	assign im_den[0] = den_s5;

	for (genvar i = 0; i < DB; i++) begin : g_cells
		dlp_div_cell u_re (
			.clk      (clk),
			.en       (en),
			.rem      (re_rem[i]),
			.nlo      (re_nlo[i]),
			.quo      (re_quo[i]),
			.den      (re_den[i]),
			.next_rem (re_rem[i+1]),
			.next_nlo (re_nlo[i+1]),
			.next_quo (re_quo[i+1]),
			.next_den (re_den[i+1])
		);
		dlp_div_cell u_im (
			.clk      (clk),
			.en       (en),
			.rem      (im_rem[i]),
			.nlo      (im_nlo[i]),
			.quo      (im_quo[i]),
			.den      (im_den[i]),
			.next_rem (im_rem[i+1]),
			.next_nlo (im_nlo[i+1]),
			.next_quo (im_quo[i+1]),
			.next_den (im_den[i+1])
		);
	end

	// flags travel alongside the cells
	dlp_pkg::term_flags_t flags_q [DB];

	always_ff @(posedge clk) begin
		if (en) begin
			flags_q[0] <= flags_s5;
			for (int i = 1; i < DB; i++) begin
				flags_q[i] <= flags_q[i-1];
			end
		end
	end

	dlp_pkg::term_flags_t fl;
	logic [DB-1:0] mre, mim;
	logic [TW-1:0] sre;
	dlp_pkg::term_res_t res_q;

	assign fl  = flags_q[DB-1];
	assign mre = fl.big_re ? dlp_pkg::TERM_MAX : re_quo[DB];
	assign mim = fl.big_im ? dlp_pkg::TERM_MAX : im_quo[DB];
	assign sre = fl.a_neg ? TW'(-{2'b00, mre}) : TW'(mre);

	always_ff @(posedge clk) begin
		if (en) begin
			// a zero denominator drops the term and flags it
			res_q.re    <= fl.zero ? '0 : sre;
			res_q.im    <= fl.zero ? '0 : TW'(mim);
			res_q.fault <= fl.zero | fl.big_re | fl.big_im;
		end
	end

	assign res = res_q;

endmodule
`default_nettype wire
